>>> src/lsfbe_pkg.sv
package lsfbe_pkg;

  typedef enum logic [2:0] {
    ACT_RGB    = 3'd0,
    ACT_RGBW   = 3'd1,
    ACT_PACKED = 3'd2,
    ACT_WHEEL  = 3'd3,
    ACT_SWEEP  = 3'd4,
    ACT_DOT    = 3'd5,
    ACT_READ   = 3'd6,
    ACT_NONE   = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_BYTES = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_BYTES   = 2'd0,
    CFG_LENGTH  = 2'd1,
    CFG_COLUMNS = 2'd2,
    CFG_LEVEL   = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADDR,
    S_DIVW,
    S_DIVD,
    S_RD,
    S_MOD,
    S_CLEAR,
    S_SWEEP_RD,
    S_SWEEP_WR,
    S_DOT_RD,
    S_DOT_WR,
    S_OUT
  } state_e;

endpackage

>>> src/led_strip_frame_buffer_effects_top.sv
// channel | dir | tdata fields (lsb up)
// s_axis  | in  | action, use_row_col, led_index, row, column, red, green, blue, white,
//         |     | color_word, wheel_or_step (114 bits in 120)
// m_axis  | out | status, pixel_byte0..3 (34 bits in 40)
// cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i
// a write or read runs S_ADDR, S_RD, S_MOD, S_OUT; a failed check S_ADDR, S_RD, S_OUT;
// a failed sweep or dot step and action 7 run S_ADDR, S_OUT; transfers are taken only in idle
// the wheel adds a divide unless max_level is 0; sweep reads, divides and writes each led (no
// divide when max_level is 0), dot step one divide and then a read and a write per led
// after reset a clearing pass zeroes all MAX_LEDS words before the first transfer is taken
// a held result waits in the output register; the next item is taken and waits at its end
module led_strip_frame_buffer_effects_top #(
  parameter int MAX_LEDS = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,   // action,use_row_col,led_index,row,column,r,g,b,w,word,ws
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,   // status,pixel_byte0,pixel_byte1,pixel_byte2,pixel_byte3
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [10:0]  cfg_data_i
);

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  logic [31:0] mem [MAX_LEDS];
  logic [31:0] rdata_q;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  logic [2:0]  bpl_q;
  logic [10:0] len_cfg_q, cols_q;
  logic [7:0]  lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpl_q <= 3'd3; len_cfg_q <= 11'd1024; cols_q <= 11'd1024; lvl_q <= 8'd255;
    end else if (cfg_we_i) begin
      unique case (lsfbe_pkg::cfg_e'(cfg_idx_i))
        lsfbe_pkg::CFG_BYTES:   bpl_q <= cfg_data_i[2:0];
        lsfbe_pkg::CFG_LENGTH:  len_cfg_q <= cfg_data_i;
        lsfbe_pkg::CFG_COLUMNS: cols_q <= cfg_data_i;
        lsfbe_pkg::CFG_LEVEL:   lvl_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [16:0] len;
  assign len = ({6'd0, len_cfg_q} > 17'(MAX_LEDS)) ? 17'(MAX_LEDS) : {6'd0, len_cfg_q};

  // input fields
  logic [119:0] in_q;
  lsfbe_pkg::action_e act;
  logic        rc;
  logic [9:0]  idx_f, row_f, col_f;
  logic [7:0]  r_f, g_f, b_f, w_f;
  logic [31:0] word_f;
  logic [15:0] ws_f;
  assign act    = lsfbe_pkg::action_e'(in_q[2:0]);
  assign rc     = in_q[3];
  assign idx_f  = in_q[13:4];
  assign row_f  = in_q[23:14];
  assign col_f  = in_q[33:24];
  assign r_f    = in_q[41:34];
  assign g_f    = in_q[49:42];
  assign b_f    = in_q[57:50];
  assign w_f    = in_q[65:58];
  assign word_f = in_q[97:66];
  assign ws_f   = in_q[113:98];

  lsfbe_pkg::state_e st_q, st_d;
  logic [21:0] addr_q, addr_d;
  logic [16:0] i_q, i_d;
  logic [1:0]  stat_q, stat_d;
  logic [31:0] rd_q, rd_d;
  // shared restoring divider, 17-bit dividend, quotient kept modulo 6
  logic [16:0] dnd_q, dnd_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [4:0]  dcnt_q, dcnt_d;
  logic [2:0]  qm_q, qm_d;
  logic [16:0] pos_q, pos_d;
  logic [7:0]  cr_q, cg_q, cb_q, cr_d, cg_d, cb_d;
  logic        busy_divdot_q, busy_divdot_d;
  logic        ovalid_q, ovalid_d;
  logic [33:0] odata_q, odata_d;
  logic        take;

  logic [17:0] rsh;
  logic        qbit;
  logic [3:0]  qsh;
  assign rsh  = {rem_q, dnd_q[16]};
  assign qbit = (rsh >= {1'b0, dvs_q});
  assign qsh  = {qm_q, qbit};

  function automatic logic [23:0] wheel(input logic [7:0] m, input logic [2:0] s,
                                        input logic [7:0] f);
    logic [7:0] mf;
    mf = m - f;
    if (m == 8'd0) return 24'd0;
    unique case (s)
      3'd0: return {8'd0, f, m};
      3'd1: return {8'd0, m, mf};
      3'd2: return {f, m, 8'd0};
      3'd3: return {m, mf, 8'd0};
      3'd4: return {m, 8'd0, f};
      default: return {mf, 8'd0, m};
    endcase
  endfunction

  logic [23:0] wcol;
  assign wcol = wheel(lvl_q, qm_q, rem_q[7:0]);

  assign s_axis_tready = (st_q == lsfbe_pkg::S_IDLE);
  assign take = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {6'd0, odata_q};

  always_comb begin
    st_d = st_q; addr_d = addr_q; i_d = i_q; stat_d = stat_q; rd_d = rd_q;
    dnd_d = dnd_q; rem_d = rem_q; dvs_d = dvs_q; dcnt_d = dcnt_q; qm_d = qm_q;
    pos_d = pos_q; cr_d = cr_q; cg_d = cg_q; cb_d = cb_q;
    busy_divdot_d = busy_divdot_q;
    ovalid_d = ovalid_q; odata_d = odata_q;
    we = 1'b0; waddr = addr_q[AW-1:0]; raddr = addr_q[AW-1:0]; wdata = rdata_q;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    unique case (st_q)
      lsfbe_pkg::S_CLEAR: begin
        we = 1'b1; waddr = i_q[AW-1:0]; wdata = 32'd0;
        i_d = i_q + 17'd1;
        if (i_q == 17'(MAX_LEDS - 1)) st_d = lsfbe_pkg::S_IDLE;
      end
      lsfbe_pkg::S_IDLE: if (take) st_d = lsfbe_pkg::S_ADDR;
      lsfbe_pkg::S_ADDR: begin
        addr_d = rc ? 22'(row_f * cols_q) + 22'(col_f) : 22'(idx_f);
        stat_d = lsfbe_pkg::ST_DONE; rd_d = 32'd0; i_d = 17'd0;
        st_d = lsfbe_pkg::S_RD;
        unique case (act)
          lsfbe_pkg::ACT_SWEEP, lsfbe_pkg::ACT_DOT: begin
            if (len == 17'd0) begin stat_d = lsfbe_pkg::ST_RANGE; st_d = lsfbe_pkg::S_OUT; end
            else if (bpl_q != 3'd3) begin
              stat_d = lsfbe_pkg::ST_BYTES; st_d = lsfbe_pkg::S_OUT;
            end else if (act == lsfbe_pkg::ACT_DOT) begin
              dnd_d = {1'b0, ws_f}; dvs_d = len; dcnt_d = 5'd0;
              qm_d = 3'd0; rem_d = '0; busy_divdot_d = 1'b1; st_d = lsfbe_pkg::S_DIVD;
            end else begin
              addr_d = '0; st_d = lsfbe_pkg::S_SWEEP_RD;
            end
          end
          lsfbe_pkg::ACT_NONE: st_d = lsfbe_pkg::S_OUT;
          default: ;
        endcase
      end
      lsfbe_pkg::S_RD: begin
        // address ready, launch read and checks
        st_d = lsfbe_pkg::S_MOD;
        unique case (act)
          lsfbe_pkg::ACT_RGB:
            if (bpl_q != 3'd3) begin stat_d = lsfbe_pkg::ST_BYTES; st_d = lsfbe_pkg::S_OUT; end
          lsfbe_pkg::ACT_RGBW:
            if (bpl_q != 3'd4) begin stat_d = lsfbe_pkg::ST_BYTES; st_d = lsfbe_pkg::S_OUT; end
          lsfbe_pkg::ACT_WHEEL:
            if ({1'b0, addr_q} < {6'd0, len} && bpl_q != 3'd3) begin
              stat_d = lsfbe_pkg::ST_BYTES; st_d = lsfbe_pkg::S_OUT;
            end
          default: ;
        endcase
        if (st_d == lsfbe_pkg::S_MOD && !({1'b0, addr_q} < {6'd0, len})) begin
          stat_d = lsfbe_pkg::ST_RANGE; st_d = lsfbe_pkg::S_OUT;
        end
        if (st_d == lsfbe_pkg::S_MOD && act == lsfbe_pkg::ACT_WHEEL) begin
          if (lvl_q == 8'd0) begin
            qm_d = 3'd0; rem_d = '0;
          end else begin
            dnd_d = {1'b0, ws_f}; dvs_d = {9'd0, lvl_q}; qm_d = 3'd0; rem_d = '0;
            dcnt_d = 5'd0; st_d = lsfbe_pkg::S_DIVW;
          end
        end
      end
      lsfbe_pkg::S_DIVW, lsfbe_pkg::S_DIVD: begin
        dnd_d = {dnd_q[15:0], 1'b0};
        if (qbit) rem_d = 17'(rsh - {1'b0, dvs_q});
        else rem_d = rsh[16:0];
        qm_d = (qsh >= 4'd6) ? 3'(qsh - 4'd6) : qsh[2:0];
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd16) begin
          if (st_q == lsfbe_pkg::S_DIVD) begin
            st_d = lsfbe_pkg::S_DOT_RD; busy_divdot_d = 1'b0;
          end else if (busy_divdot_q) st_d = lsfbe_pkg::S_SWEEP_WR;
          else st_d = lsfbe_pkg::S_MOD;
        end
      end
      lsfbe_pkg::S_MOD: begin
        we = 1'b1; st_d = lsfbe_pkg::S_OUT;
        unique case (act)
          lsfbe_pkg::ACT_RGB:  wdata = {rdata_q[31:24], b_f, g_f, r_f};
          lsfbe_pkg::ACT_RGBW: wdata = {w_f, b_f, g_f, r_f};
          lsfbe_pkg::ACT_PACKED: begin
            wdata = rdata_q;
            wdata[7:0] = word_f[23:16];
            if (bpl_q > 3'd1) wdata[15:8] = word_f[15:8];
            if (bpl_q > 3'd2) wdata[23:16] = word_f[7:0];
            if (bpl_q > 3'd3) wdata[31:24] = word_f[31:24];
          end
          lsfbe_pkg::ACT_WHEEL: wdata = {rdata_q[31:24], wcol};
          default: begin we = 1'b0; rd_d = rdata_q; end
        endcase
      end
      lsfbe_pkg::S_SWEEP_RD: begin
        // read word at addr, divide its colour index
        dnd_d = {1'b0, 16'(addr_q[15:0] + ws_f)}; dvs_d = {9'd0, lvl_q};
        qm_d = 3'd0; rem_d = '0; dcnt_d = 5'd0; busy_divdot_d = 1'b1;
        st_d = (lvl_q == 8'd0) ? lsfbe_pkg::S_SWEEP_WR : lsfbe_pkg::S_DIVW;
      end
      lsfbe_pkg::S_SWEEP_WR: begin
        we = 1'b1; wdata = {rdata_q[31:24], wcol};
        addr_d = addr_q + 22'd1; busy_divdot_d = 1'b0;
        st_d = ({6'd0, addr_q[15:0]} == 22'(len - 17'd1)) ?
               lsfbe_pkg::S_OUT : lsfbe_pkg::S_SWEEP_RD;
      end
      lsfbe_pkg::S_DOT_RD: begin
        if (i_q == 17'd0) begin
          if (qm_q[0]) pos_d = 17'(len - rem_q - 17'd1);
          else pos_d = rem_q;
          unique case (qm_q)
            3'd0: begin cr_d = lvl_q; cg_d = 8'd0; cb_d = 8'd0; end
            3'd1: begin cr_d = 8'd0; cg_d = lvl_q; cb_d = 8'd0; end
            3'd2: begin cr_d = 8'd0; cg_d = 8'd0; cb_d = lvl_q; end
            3'd3: begin cr_d = lvl_q >> 1; cg_d = lvl_q >> 1; cb_d = 8'd0; end
            3'd4: begin cr_d = 8'd0; cg_d = lvl_q >> 1; cb_d = lvl_q >> 1; end
            default: begin cr_d = lvl_q >> 1; cg_d = 8'd0; cb_d = lvl_q >> 1; end
          endcase
        end
        raddr = i_q[AW-1:0];
        st_d = lsfbe_pkg::S_DOT_WR;
      end
      lsfbe_pkg::S_DOT_WR: begin
        we = 1'b1; waddr = i_q[AW-1:0];
        wdata = (i_q == pos_q) ? {rdata_q[31:24], cb_q, cg_q, cr_q} :
                {rdata_q[31:24], 1'b0, rdata_q[23:17], 1'b0, rdata_q[15:9],
                 1'b0, rdata_q[7:1]};
        i_d = i_q + 17'd1;
        st_d = (i_q == 17'(len - 17'd1)) ? lsfbe_pkg::S_OUT : lsfbe_pkg::S_DOT_RD;
      end
      lsfbe_pkg::S_OUT: if (!ovalid_q) begin
        ovalid_d = 1'b1;
        odata_d = {rd_q[31:24], rd_q[23:16], rd_q[15:8], rd_q[7:0], stat_q};
        st_d = lsfbe_pkg::S_IDLE;
      end
      default: st_d = lsfbe_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= lsfbe_pkg::S_CLEAR; i_q <= '0; ovalid_q <= 1'b0; busy_divdot_q <= 1'b0;
    end else begin
      st_q <= st_d; i_q <= i_d; ovalid_q <= ovalid_d; busy_divdot_q <= busy_divdot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) in_q <= s_axis_tdata;
    addr_q <= addr_d; stat_q <= stat_d; rd_q <= rd_d;
    dnd_q <= dnd_d; rem_q <= rem_d; dvs_q <= dvs_d; dcnt_q <= dcnt_d; qm_q <= qm_d;
    pos_q <= pos_d; cr_q <= cr_d; cg_q <= cg_d; cb_q <= cb_d;
    odata_q <= odata_d;
  end

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> st_q == lsfbe_pkg::S_ADDR) else $error("item not started");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3) else $error("bad status");
  a_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1:0] != 2'd0) |-> m_axis_tdata[33:2] == 32'd0)
    else $error("data on failed item");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !m_axis_tready) |=> ovalid_q && $stable(odata_q))
    else $error("result lost");

endmodule
